// ===== rtl/cso_pkg.sv =====
package cso_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROM,
        S_X,
        S_MXX,
        S_X2,
        S_MX3,
        S_T3,
        S_WST,
        S_DIV,
        S_MW,
        S_ACC,
        S_MR,
        S_REC,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_XX,
        MUL_X2X,
        MUL_TW,
        MUL_RC
    } t_mul;

    typedef struct packed {
        logic load_phase;
        logic adv_phase;
        logic rom_rd;
        logic x_ld;
        logic mul_en;
        t_mul mul_sel;
        logic x2_ld;
        logic t3_ld;
        logic div_start;
        logic div_step;
        logic acc;
        logic rec;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic more;
        logic k_one;
        logic out_free;
    } t_status;

    localparam logic [1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [1:0] CFG_BASE_FREQ  = 2'd1;
    localparam logic [1:0] CFG_HARM_LIMIT = 2'd2;

    localparam logic [22:0] BASE_FREQ_RST  = 23'd112640;
    localparam logic [9:0]  HARM_LIMIT_RST = 10'd34;
    localparam int unsigned FALL_TOP  = 3840000;
    localparam int unsigned FALL_BAND = 128000;
    localparam int unsigned DIV_STEPS = 31;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        return v[32] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [32:0] sat31(input logic signed [39:0] v);
        if (v > 40'sd2147483648) begin
            return 33'sd2147483648;
        end else if (v < -40'sd2147483648) begin
            return -33'sd2147483648;
        end
        return 33'(v);
    endfunction

endpackage

// ===== rtl/cso_in_if.sv =====
interface cso_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] phase_value;

    modport source (output valid, output cmd, output phase_value, input ready);
    modport sink (input valid, input cmd, input phase_value, output ready);
endinterface

// ===== rtl/cso_out_if.sv =====
interface cso_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/cso_cfg_if.sv =====
interface cso_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/chebyshev_square_oscillator.sv =====
// Band-limited square oscillator. A tick word (cmd 0) advances the 32-bit phase by phase_step,
// reads sin(2*pi*phase) from a quarter-wave ROM and sums the odd Chebyshev harmonics
// below harmonic_limit (harmonics 1 and 3 always) with 1/k weighting and a linear falloff
// toward 15 kHz, giving one saturated Q1.22 sample. A load word (cmd 1) sets the phase and
// gives no sample. Each harmonic is set by a bit-serial weight divider plus the shared 32x32
// multiplier used for the recurrence and the weighting. The finished sample sits in an output
// register, so the next word is taken while it waits.
module chebyshev_square_oscillator #(
    parameter int MAX_HARMONIC     = 1023,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cso_in_if.sink      i_in,
    cso_out_if.source   o_out,
    cso_cfg_if.sink     i_cfg
);

    cso_pkg::t_cmd    w_cmd;
    cso_pkg::t_status w_status;
    logic             w_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    cso_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_load  (i_in.cmd),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    cso_dpath #(
        .MAX_HARMONIC     (MAX_HARMONIC),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_phase_value (i_in.phase_value),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_sample  (o_out.sample)
    );

    a_load_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd) |=> !$rose(o_out.valid))
        else $error("load word produced a sample");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.cmd) |=> !i_in.ready)
        else $error("input taken while a tick is in progress");

    a_sample_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("sample appeared without a tick in progress");

endmodule

// ===== rtl/cso_ctrl.sv =====
module cso_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_load,
    input  cso_pkg::t_status  i_status,
    output logic              o_in_ready,
    output cso_pkg::t_cmd     o_cmd
);

    cso_pkg::t_state r_state;
    cso_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cso_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cso_pkg::S_IDLE: begin
                if (i_in_valid && !i_in_load) begin
                    n_state = cso_pkg::S_ROM;
                end
            end
            cso_pkg::S_ROM: n_state = cso_pkg::S_X;
            cso_pkg::S_X:   n_state = cso_pkg::S_MXX;
            cso_pkg::S_MXX: n_state = cso_pkg::S_X2;
            cso_pkg::S_X2:  n_state = cso_pkg::S_MX3;
            cso_pkg::S_MX3: n_state = cso_pkg::S_T3;
            cso_pkg::S_T3:  n_state = cso_pkg::S_WST;
            cso_pkg::S_WST: n_state = cso_pkg::S_DIV;
            cso_pkg::S_DIV: begin
                if (i_status.div_last) begin
                    n_state = cso_pkg::S_MW;
                end
            end
            cso_pkg::S_MW:  n_state = cso_pkg::S_ACC;
            cso_pkg::S_ACC: begin
                priority if (i_status.k_one) begin
                    n_state = cso_pkg::S_WST;
                end else if (i_status.more) begin
                    n_state = cso_pkg::S_MR;
                end else begin
                    n_state = cso_pkg::S_OUT;
                end
            end
            cso_pkg::S_MR:  n_state = cso_pkg::S_REC;
            cso_pkg::S_REC: n_state = cso_pkg::S_WST;
            cso_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    n_state = cso_pkg::S_IDLE;
                end
            end
            default: n_state = cso_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = cso_pkg::MUL_XX;
        o_in_ready    = 1'b0;
        unique case (r_state)
            cso_pkg::S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.load_phase = i_in_valid && i_in_load;
                o_cmd.adv_phase  = i_in_valid && !i_in_load;
            end
            cso_pkg::S_ROM: o_cmd.rom_rd = 1'b1;
            cso_pkg::S_X:   o_cmd.x_ld = 1'b1;
            cso_pkg::S_MXX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = cso_pkg::MUL_XX;
            end
            cso_pkg::S_X2:  o_cmd.x2_ld = 1'b1;
            cso_pkg::S_MX3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = cso_pkg::MUL_X2X;
            end
            cso_pkg::S_T3:  o_cmd.t3_ld = 1'b1;
            cso_pkg::S_WST: o_cmd.div_start = 1'b1;
            cso_pkg::S_DIV: o_cmd.div_step = 1'b1;
            cso_pkg::S_MW: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = cso_pkg::MUL_TW;
            end
            cso_pkg::S_ACC: o_cmd.acc = 1'b1;
            cso_pkg::S_MR: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = cso_pkg::MUL_RC;
            end
            cso_pkg::S_REC: o_cmd.rec = 1'b1;
            cso_pkg::S_OUT: o_cmd.out_ld = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/cso_dpath.sv =====
module cso_dpath #(
    parameter int MAX_HARMONIC     = 1023,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cso_pkg::t_cmd       i_cmd,
    output cso_pkg::t_status    o_status,
    input  logic [31:0]         i_phase_value,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [23:0]  o_out_sample
);

    localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int KW  = $clog2(MAX_HARMONIC + 3);
    localparam int CW  = (KW + 1 > 11) ? KW + 1 : 11;
    localparam int PW  = KW + 23;
    localparam int DVW = KW + 17;
    localparam int unsigned DivTab [1:10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

    typedef logic [30:0] t_rom [0:SINE_TABLE_DEPTH];

    function automatic t_rom build_rom();
        t_rom              rom;
        longint unsigned   a;
        longint unsigned   term;
        longint            s;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            a    = (64'd1686629713 * longint'(i)) / SINE_TABLE_DEPTH;
            term = a;
            s    = longint'(a);
            for (int n = 1; n <= 10; n++) begin
                term = (term * a) >> 30;
                term = ((term * a) >> 30) / DivTab[n];
                if (n % 2 == 1) begin
                    s = s - longint'(term);
                end else begin
                    s = s + longint'(term);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            if (s > 64'sd1073741824) begin
                s = 64'sd1073741824;
            end
            rom[i] = 31'(s);
        end
        return rom;
    endfunction

    localparam t_rom SineRom = build_rom();

    logic [31:0]         r_phase_step;
    logic [22:0]         r_base_freq;
    logic [9:0]          r_harm;
    logic [31:0]         r_phase;
    logic [30:0]         r_rom;
    logic                r_neg;
    logic signed [32:0]  r_x;
    logic signed [32:0]  r_x2;
    logic signed [32:0]  r_x21;
    logic signed [32:0]  r_tprev;
    logic signed [32:0]  r_tcur;
    logic signed [39:0]  r_sum;
    logic [KW-1:0]       r_k;
    logic [63:0]         r_pm;
    logic                r_pneg;
    logic [DVW-1:0]      r_dvs;
    logic [DVW-1:0]      r_rem;
    logic [30:0]         r_dnd;
    logic [30:0]         r_q;
    logic [4:0]          r_dcnt;
    logic                r_ovalid;
    logic signed [23:0]  r_sample;

    logic [29+IW:0]      w_scaled;
    logic [IW-1:0]       w_idx;
    logic [IW-1:0]       w_addr;
    logic signed [32:0]  w_ma;
    logic signed [32:0]  w_mb;
    logic [33:0]         w_rmag;
    logic signed [35:0]  w_rnd;
    logic signed [39:0]  w_t3;
    logic signed [39:0]  w_tn;
    logic [PW-1:0]       w_kb;
    logic [PW-1:0]       w_diff;
    logic [16:0]         w_num;
    logic [DVW:0]        w_trial;
    logic [CW-1:0]       w_kn;
    logic [39:0]         w_smag;
    logic [31:0]         w_r;
    logic signed [23:0]  w_sample;

    assign w_scaled = (30 + IW)'(r_phase[29:0]) * (30 + IW)'(SINE_TABLE_DEPTH);
    assign w_idx    = w_scaled[29+IW:30];
    assign w_addr   = r_phase[30] ? IW'(SINE_TABLE_DEPTH) - w_idx : w_idx;

    always_comb begin
        unique case (i_cmd.mul_sel)
            cso_pkg::MUL_XX: begin
                w_ma = r_x;
                w_mb = r_x;
            end
            cso_pkg::MUL_X2X: begin
                w_ma = r_x2;
                w_mb = r_x;
            end
            cso_pkg::MUL_TW: begin
                w_ma = (r_k == KW'(1)) ? r_x : r_tcur;
                w_mb = $signed({2'b00, r_q});
            end
            cso_pkg::MUL_RC: begin
                w_ma = r_x21;
                w_mb = r_tcur;
            end
            default: begin
                w_ma = r_x;
                w_mb = r_x;
            end
        endcase
    end

    assign w_rmag = 34'((r_pm + 64'd536870912) >> 30);
    assign w_rnd  = r_pneg ? -$signed({2'b00, w_rmag}) : $signed({2'b00, w_rmag});
    assign w_t3   = (40'(w_rnd) <<< 2) - 40'(r_x) - (40'(r_x) <<< 1);
    assign w_tn   = 40'(w_rnd) - 40'(r_tprev);

    assign w_kb   = PW'(r_k) * PW'(r_base_freq);
    assign w_diff = PW'(cso_pkg::FALL_TOP) - w_kb;
    always_comb begin
        priority if (w_kb >= PW'(cso_pkg::FALL_TOP)) begin
            w_num = '0;
        end else if (w_diff > PW'(cso_pkg::FALL_BAND)) begin
            w_num = 17'(cso_pkg::FALL_BAND);
        end else begin
            w_num = 17'(w_diff);
        end
    end

    assign w_trial = {r_rem, r_dnd[30]};
    assign w_kn    = CW'(r_k) + CW'(2);

    assign w_smag = r_sum[39] ? 40'(-r_sum) : 40'(r_sum);
    assign w_r    = 32'((w_smag + 40'd128) >> 8);
    always_comb begin
        priority if (!r_sum[39] && w_r > 32'd8388607) begin
            w_sample = 24'sh7fffff;
        end else if (r_sum[39] && w_r > 32'd8388608) begin
            w_sample = -24'sh800000;
        end else if (r_sum[39]) begin
            w_sample = 24'(-$signed({1'b0, w_r}));
        end else begin
            w_sample = 24'(w_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_base_freq  <= cso_pkg::BASE_FREQ_RST;
            r_harm       <= cso_pkg::HARM_LIMIT_RST;
            r_phase      <= '0;
            r_ovalid     <= 1'b0;
            r_dcnt       <= '0;
            r_k          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cso_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                    cso_pkg::CFG_BASE_FREQ:  r_base_freq  <= i_cfg_data[22:0];
                    cso_pkg::CFG_HARM_LIMIT: r_harm       <= i_cfg_data[9:0];
                    default: r_harm <= r_harm;
                endcase
            end
            if (i_cmd.load_phase) begin
                r_phase <= i_phase_value;
            end else if (i_cmd.adv_phase) begin
                r_phase <= r_phase + r_phase_step;
            end
            if (i_cmd.div_start) begin
                r_dcnt <= 5'(cso_pkg::DIV_STEPS);
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - 5'd1;
            end
            if (i_cmd.t3_ld) begin
                r_k <= KW'(1);
            end else if (i_cmd.acc) begin
                r_k <= r_k + KW'(2);
            end
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rom_rd) begin
            r_rom <= SineRom[w_addr];
            r_neg <= r_phase[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_ld) begin
            r_x <= r_neg ? -$signed({2'b00, r_rom}) : $signed({2'b00, r_rom});
        end
        if (i_cmd.mul_en) begin
            r_pm   <= 64'(cso_pkg::mag33(w_ma)) * 64'(cso_pkg::mag33(w_mb));
            r_pneg <= w_ma[32] ^ w_mb[32];
        end
        if (i_cmd.x2_ld) begin
            r_x2  <= 33'(w_rnd);
            r_x21 <= 33'((w_rnd <<< 2) - 36'sd2147483648);
        end
        if (i_cmd.t3_ld) begin
            r_tprev <= r_x;
            r_tcur  <= cso_pkg::sat31(w_t3);
            r_sum   <= '0;
        end
        if (i_cmd.rec) begin
            r_tprev <= r_tcur;
            r_tcur  <= cso_pkg::sat31(w_tn);
        end
        if (i_cmd.acc) begin
            r_sum <= r_k[1] ? r_sum - 40'(w_rnd) : r_sum + 40'(w_rnd);
        end
        if (i_cmd.div_start) begin
            r_dvs <= DVW'(r_k) * DVW'(cso_pkg::FALL_BAND);
            r_rem <= DVW'(w_num[16:1]);
            r_dnd <= {w_num[0], 30'd0};
        end else if (i_cmd.div_step) begin
            r_dnd <= {r_dnd[29:0], 1'b0};
            if (w_trial >= {1'b0, r_dvs}) begin
                r_rem <= DVW'(w_trial - {1'b0, r_dvs});
                r_q   <= {r_q[29:0], 1'b1};
            end else begin
                r_rem <= DVW'(w_trial);
                r_q   <= {r_q[29:0], 1'b0};
            end
        end
        if (i_cmd.out_ld) begin
            r_sample <= w_sample;
        end
    end

    assign o_status.div_last = (r_dcnt == 5'd1);
    assign o_status.more     = (w_kn < CW'(r_harm)) && (w_kn <= CW'(MAX_HARMONIC));
    assign o_status.k_one    = (r_k == KW'(1));
    assign o_status.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid       = r_ovalid;
    assign o_out_sample      = r_sample;

endmodule
